[rtl/s7j3d_pkg.sv]
// Shared constants for the 3D seven-point Jacobi stencil block.
// No dependencies; imported by the front, back and top-level modules.
`default_nettype none
package s7j3d_pkg;
  localparam int unsigned GRID_EDGE_W   = 6;   // width of the grid_edge register
  localparam int unsigned GRID_EDGE_RST = 62;  // grid_edge after reset
  localparam int unsigned N_TAPS        = 6;   // face neighbors in one update
  localparam int unsigned N_HIST_RD     = 5;   // neighbors taken from history
  localparam int unsigned DIV_CONST     = 6;   // divisor of the neighbor sum
  localparam int unsigned DIV_STEPS     = 8;   // quotient bits per divider stage
  localparam int unsigned ONE_Q16       = 65536;
endpackage
`default_nettype wire

[rtl/s7j3d_fifo.sv]
// Small register FIFO that decouples the stencil front end from the arithmetic back end.
// No dependencies.
`default_nettype none
module s7j3d_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output logic [DATA_W-1:0]      pop_data_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end
endmodule
`default_nettype wire

[rtl/s7j3d_front.sv]
// Stencil front end: grid edge register, position counters, plane history memories.
// Depends on s7j3d_pkg; feeds interior cells with their neighbors into s7j3d_fifo.
`default_nettype none
module s7j3d_front
  import s7j3d_pkg::*;
#(
  parameter int unsigned MAX_EDGE    = 62,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned CW          = 6,
  parameter int unsigned QW          = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [GRID_EDGE_W-1:0] cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [VALUE_WIDTH-1:0] cell_value_i,
  input  wire logic                   first_cell_i,
  output logic                        push_valid_o,
  input  wire logic                   push_ready_i,
  output logic [QW-1:0]               push_data_o
);
  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned PAD   = MAX_EDGE + 2;
  localparam int unsigned EW    = CW + 1;
  localparam int unsigned EEW   = 2 * EW;
  localparam int unsigned AW    = $clog2(2 * PAD * PAD);
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned N_RST = (GRID_EDGE_RST > MAX_EDGE) ? MAX_EDGE : GRID_EDGE_RST;
  localparam int unsigned E_RST = N_RST + 2;
  localparam int unsigned EE_RST = E_RST * E_RST;

  // grid geometry, settled when the register is written
  logic [CW-1:0]  n_q;
  logic [EW-1:0]  e_q;
  logic [EEW-1:0] ee_q;
  logic [AW-1:0]  off_q [N_HIST_RD];
  logic [CW-1:0]  n_d;
  logic [EW-1:0]  e_d;
  logic [EEW-1:0] ee_d;

  logic [CW-1:0]  x_q, y_q, z_q;
  logic [CW-1:0]  cx, cy, cz;
  logic [AW-1:0]  pos_lin;
  logic [AW-1:0]  raddr [N_HIST_RD];
  logic           accept, interior, is_last;

  logic [W-1:0]   mem_q [N_HIST_RD][DEPTH];
  logic [W-1:0]   rd_q  [N_HIST_RD];

  logic           s1_valid_q, s1_int_q, s1_last_q;
  logic [W-1:0]   s1_v_q;
  logic [CW-1:0]  s1_x_q, s1_y_q, s1_z_q;
  logic           s1_go;

  always_comb begin
    if (cfg_data_i == '0) begin
      n_d = CW'(1);
    end else if (int'(cfg_data_i) > int'(MAX_EDGE)) begin
      n_d = CW'(MAX_EDGE);
    end else begin
      n_d = CW'(cfg_data_i);
    end
    e_d  = EW'(n_d) + EW'(2);
    ee_d = EEW'(e_d) * EEW'(e_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= CW'(N_RST);
      e_q      <= EW'(E_RST);
      ee_q     <= EEW'(EE_RST);
      off_q[0] <= AW'(EE_RST + 1);
      off_q[1] <= AW'(EE_RST - 1);
      off_q[2] <= AW'(EE_RST + E_RST);
      off_q[3] <= AW'(EE_RST - E_RST);
      off_q[4] <= AW'(2 * EE_RST);
    end else if (cfg_we_i) begin
      n_q      <= n_d;
      e_q      <= e_d;
      ee_q     <= ee_d;
      off_q[0] <= AW'(ee_d + EEW'(1));
      off_q[1] <= AW'(ee_d - EEW'(1));
      off_q[2] <= AW'(ee_d + EEW'(e_d));
      off_q[3] <= AW'(ee_d - EEW'(e_d));
      off_q[4] <= AW'({ee_d, 1'b0});
    end
  end

  assign accept = in_valid_i && in_ready_o;
  assign cx = first_cell_i ? '0 : x_q;
  assign cy = first_cell_i ? '0 : y_q;
  assign cz = first_cell_i ? '0 : z_q;

  assign pos_lin = AW'(cx) + AW'(e_q) * AW'(cy) + AW'(ee_q) * AW'(cz);

  always_comb begin
    for (int k = 0; k < N_HIST_RD; k++) begin
      raddr[k] = pos_lin - off_q[k];
    end
  end

  // the cell one plane below the current one is the one being updated
  assign interior = (cx != '0) && (cx <= n_q) && (cy != '0) && (cy <= n_q) &&
                    (EW'(cz) >= EW'(2)) && (EW'(cz) <= EW'(n_q) + EW'(1));
  assign is_last  = (cx == n_q) && (cy == n_q) && (EW'(cz) == EW'(n_q) + EW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
    end else if (accept) begin
      if (EW'(cx) + EW'(1) >= e_q) begin
        x_q <= '0;
        if (EW'(cy) + EW'(1) >= e_q) begin
          y_q <= '0;
          z_q <= (EW'(cz) + EW'(1) >= e_q) ? '0 : cz + 1'b1;
        end else begin
          y_q <= cy + 1'b1;
          z_q <= cz;
        end
      end else begin
        x_q <= cx + 1'b1;
        y_q <= cy;
        z_q <= cz;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < N_HIST_RD; k++) begin
        mem_q[k][pos_lin] <= cell_value_i;
        rd_q[k]           <= mem_q[k][raddr[k]];
      end
    end
  end

  // drop cells that update nothing, hold the rest until the queue has room
  assign s1_go      = !s1_int_q || push_ready_i;
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_int_q   <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_int_q   <= interior;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
      s1_int_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_v_q    <= cell_value_i;
      s1_x_q    <= cx;
      s1_y_q    <= cy;
      s1_z_q    <= cz - 1'b1;
      s1_last_q <= is_last;
    end
  end

  assign push_valid_o = s1_valid_q && s1_int_q;
  assign push_data_o  = {s1_last_q, s1_z_q, s1_y_q, s1_x_q,
                         rd_q[4], rd_q[3], rd_q[2], rd_q[1], rd_q[0], s1_v_q};
endmodule
`default_nettype wire

[rtl/s7j3d_back.sv]
// Stencil back end: six-term sum, divide by six toward zero, add one, saturate.
// Depends on s7j3d_pkg; takes items from s7j3d_fifo and holds the output register.
`default_nettype none
module s7j3d_back
  import s7j3d_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned CW          = 6,
  parameter int unsigned QW          = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   pop_valid_i,
  output logic                        pop_ready_o,
  input  wire logic [QW-1:0]          pop_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0]      new_value_o,
  output logic [CW-1:0]               pos_x_o,
  output logic [CW-1:0]               pos_y_o,
  output logic [CW-1:0]               pos_z_o,
  output logic                        last_result_o
);
  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned SW = W + 3;
  localparam int unsigned MW = W + 2;
  localparam int unsigned RW = MW + 2;
  localparam int unsigned IW = 3 * CW + 1;
  localparam int unsigned NS = (MW + DIV_STEPS - 1) / DIV_STEPS;
  localparam logic signed [RW-1:0] MAXV = {{(RW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [RW-1:0] MINV = {{(RW - W + 1){1'b1}}, {(W - 1){1'b0}}};

  function automatic logic [MW+2:0] div_step(input logic [2:0] rem_in,
                                             input logic [MW-1:0] m_in,
                                             input int steps);
    logic [2:0]    r;
    logic [MW-1:0] m;
    logic [3:0]    t;
    r = rem_in;
    m = m_in;
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (i < steps) begin
        t = {r, m[MW-1]};
        if (t >= 4'(DIV_CONST)) begin
          r = 3'(t - 4'(DIV_CONST));
          m = {m[MW-2:0], 1'b1};
        end else begin
          r = t[2:0];
          m = {m[MW-2:0], 1'b0};
        end
      end
    end
    return {r, m};
  endfunction

  logic                 en;
  logic                 a_valid_q, b_valid_q, c_valid_q, e_valid_q, out_valid_q;
  logic signed [W:0]    a_pair_q [3];
  logic signed [SW-1:0] b_sum_q;
  logic                 c_neg_q;
  logic [MW-1:0]        c_mag_q;
  logic [IW-1:0]        a_info_q, b_info_q, c_info_q, e_info_q;
  logic                 d_valid_q [NS];
  logic                 d_neg_q   [NS];
  logic [2:0]           d_rem_q   [NS];
  logic [MW-1:0]        d_m_q     [NS];
  logic [IW-1:0]        d_info_q  [NS];
  logic signed [MW:0]   e_quot_q;
  logic signed [RW-1:0] res;
  logic [W-1:0]         out_value_q;
  logic [IW-1:0]        out_info_q;

  // the whole pipeline advances whenever the output register can take a result
  assign en          = !out_valid_q || out_ready_i;
  assign pop_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q   <= pop_valid_i;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= b_valid_q;
      e_valid_q   <= d_valid_q[NS-1];
      out_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_pair_q[k] <= (W+1)'($signed(pop_data_i[2*k*W +: W])) +
                       (W+1)'($signed(pop_data_i[(2*k+1)*W +: W]));
      end
      a_info_q <= pop_data_i[N_TAPS*W +: IW];
      b_sum_q  <= SW'(a_pair_q[0]) + SW'(a_pair_q[1]) + SW'(a_pair_q[2]);
      b_info_q <= a_info_q;
      c_neg_q  <= b_sum_q[SW-1];
      c_mag_q  <= b_sum_q[SW-1] ? MW'(-b_sum_q) : MW'(b_sum_q);
      c_info_q <= b_info_q;
      e_quot_q <= d_neg_q[NS-1] ? -$signed({1'b0, d_m_q[NS-1]})
                                : $signed({1'b0, d_m_q[NS-1]});
      e_info_q <= d_info_q[NS-1];
      if (e_valid_q) begin
        out_value_q <= W'(res);
        out_info_q  <= e_info_q;
      end
    end
  end

  // long division of the magnitude by six, up to a byte of quotient per stage
  for (genvar s = 0; s < NS; s++) begin : g_div
    localparam int STEPS = (s == NS - 1) ? int'(MW - DIV_STEPS * (NS - 1)) : int'(DIV_STEPS);
    logic            in_valid, in_neg;
    logic [2:0]      in_rem;
    logic [MW-1:0]   in_m;
    logic [IW-1:0]   in_info;
    logic [MW+2:0]   stepped;

    if (s == 0) begin : g_head
      assign in_valid = c_valid_q;
      assign in_neg   = c_neg_q;
      assign in_rem   = '0;
      assign in_m     = c_mag_q;
      assign in_info  = c_info_q;
    end else begin : g_link
      assign in_valid = d_valid_q[s-1];
      assign in_neg   = d_neg_q[s-1];
      assign in_rem   = d_rem_q[s-1];
      assign in_m     = d_m_q[s-1];
      assign in_info  = d_info_q[s-1];
    end

    assign stepped = div_step(in_rem, in_m, STEPS);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_valid_q[s] <= 1'b0;
      end else if (en) begin
        d_valid_q[s] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d_neg_q[s]  <= in_neg;
        d_rem_q[s]  <= stepped[MW+2:MW];
        d_m_q[s]    <= stepped[MW-1:0];
        d_info_q[s] <= in_info;
      end
    end
  end

  always_comb begin
    res = RW'(e_quot_q) + RW'(ONE_Q16);
    if (res > MAXV) begin
      res = MAXV;
    end else if (res < MINV) begin
      res = MINV;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign new_value_o   = out_value_q;
  assign pos_x_o       = out_info_q[0 +: CW];
  assign pos_y_o       = out_info_q[CW +: CW];
  assign pos_z_o       = out_info_q[2*CW +: CW];
  assign last_result_o = out_info_q[3*CW];
endmodule
`default_nettype wire

[rtl/stencil7_jacobi_3d_top.sv]
// Top level of the streaming 3D seven-point Jacobi stencil.
// Depends on s7j3d_pkg, s7j3d_front, s7j3d_fifo and s7j3d_back.
//
// The padded grid (edge grid_edge + 2) streams in one cell per cycle, x fastest, then y,
// then z; first_cell restarts the position counters. One cell is taken every cycle for
// as long as the result side keeps up: the history memories are read once per cell at
// fixed plane offsets and the arithmetic is a straight pipeline, so nothing iterates.
// A result for interior cell (x,y,z) follows once cell (x,y,z+1) has arrived and passed the
// NS = ceil((VALUE_WIDTH + 2) / 8) divider stages (5 at the default width). A four-entry
// queue and the output register absorb short stalls of the result side. The history is not
// cleared after reset; the first two planes of a grid supply it. The user must write grid_edge
// through the cfg channel while no grid is in flow; the block itself does not enforce this.
`default_nettype none
module stencil7_jacobi_3d_top
  import s7j3d_pkg::*;
#(
  parameter int unsigned MAX_EDGE    = 62,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned CW         = $clog2(MAX_EDGE + 2)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [GRID_EDGE_W-1:0] cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [VALUE_WIDTH-1:0] cell_value_i,
  input  wire logic                   first_cell_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [VALUE_WIDTH-1:0]      new_value_o,
  output logic [CW-1:0]               pos_x_o,
  output logic [CW-1:0]               pos_y_o,
  output logic [CW-1:0]               pos_z_o,
  output logic                        last_result_o
);
  localparam int unsigned QW = N_TAPS * VALUE_WIDTH + 3 * CW + 1;

  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0] push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  s7j3d_front #(
    .MAX_EDGE    (MAX_EDGE),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CW          (CW),
    .QW          (QW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cell_value_i (cell_value_i),
    .first_cell_i (first_cell_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  s7j3d_fifo #(
    .DATA_W (QW),
    .DEPTH  (4)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  s7j3d_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .CW          (CW),
    .QW          (QW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_data_i    (pop_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .new_value_o   (new_value_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .last_result_o (last_result_o)
  );

  // a stalled front end keeps its item and data toward the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid && !push_ready |=> push_valid && $stable(push_data))
    else $error("front end dropped an item while the queue was full");

  // the final update sits on the main diagonal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_result_o |-> pos_x_o == pos_y_o && pos_y_o == pos_z_o)
    else $error("last result off the grid diagonal");

  // only interior cells are updated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pos_x_o != '0 && pos_y_o != '0 && pos_z_o != '0)
    else $error("result for a halo cell");
endmodule
`default_nettype wire
